@@ design/btsbc_pkg.sv @@
// Shared types, constants and command/status structures for the bass and
// treble shelving biquad cascade. No dependencies.
`default_nettype none

package btsbc_pkg;

  // Sizing of the block.
  localparam int MAX_CHANNELS   = 8;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 14;
  localparam int COEF_BITS      = COEF_FRAC_BITS + 4;
  localparam int CHANNEL_BITS   = 3;

  // History memory geometry: one row per channel, each row two samples.
  localparam int ADDR_BITS = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CH_SLOTS  = 1 << ADDR_BITS;
  localparam int ROW_BITS  = 2 * SAMPLE_BITS;

  // Arithmetic widths.
  localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_BITS  = PROD_BITS + 3;
  localparam int Q_BITS    = ACC_BITS - COEF_FRAC_BITS;

  // Configuration register file.
  localparam int FF_BITS        = 3 * COEF_BITS;
  localparam int FB_BITS        = 2 * COEF_BITS;
  localparam int CFG_DATA_BITS  = FF_BITS;
  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BASS_FF   = 2'd0,
    REG_BASS_FB   = 2'd1,
    REG_TREBLE_FF = 2'd2,
    REG_TREBLE_FB = 2'd3
  } cfg_reg_t;

  // Multiply-accumulate sequencing: five products per stage, plus a
  // trailing step to fold in the last registered product.
  localparam int MAC_TERMS = 5;
  localparam int STEP_BITS = 3;
  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(MAC_TERMS);

  typedef enum logic {
    STAGE_BASS   = 1'b0,
    STAGE_TREBLE = 1'b1
  } stage_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0]  sample_in;
    logic        [CHANNEL_BITS-1:0] channel_in;
  } in_payload_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0]  sample_out;
    logic        [CHANNEL_BITS-1:0] channel_out;
  } out_payload_t;

  // Controller to datapath.
  typedef struct packed {
    logic                 capture;
    logic                 mac_run;
    stage_t               stage;
    logic [STEP_BITS-1:0] step;
    logic                 round_bass;
    logic                 round_treble;
    logic                 commit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ design/btsbc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module btsbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/btsbc_ctrl.sv @@
// Sequencing state machine for the biquad cascade.
// Depends on btsbc_pkg.
`default_nettype none

module btsbc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire btsbc_pkg::status_t status,
  output btsbc_pkg::cmd_t        cmd
);

  import btsbc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_BASS       = 6'b000010,
    S_BASS_RND   = 6'b000100,
    S_TREBLE     = 6'b001000,
    S_TREBLE_RND = 6'b010000,
    S_DONE       = 6'b100000
  } state_t;

  state_t               state, state_next;
  logic [STEP_BITS-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next       = state;
    step_next        = step;
    in_ready         = 1'b0;
    cmd              = '0;
    cmd.stage        = STAGE_BASS;
    cmd.step         = step;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        step_next   = '0;
        if (in_valid) begin
          state_next = S_BASS;
        end
      end
      S_BASS: begin
        cmd.mac_run = 1'b1;
        step_next   = step + 1'b1;
        if (step == STEP_LAST) begin
          step_next  = '0;
          state_next = S_BASS_RND;
        end
      end
      S_BASS_RND: begin
        cmd.round_bass = 1'b1;
        state_next     = S_TREBLE;
      end
      S_TREBLE: begin
        cmd.mac_run = 1'b1;
        cmd.stage   = STAGE_TREBLE;
        step_next   = step + 1'b1;
        if (step == STEP_LAST) begin
          step_next  = '0;
          state_next = S_TREBLE_RND;
        end
      end
      S_TREBLE_RND: begin
        cmd.round_treble = 1'b1;
        state_next       = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/btsbc_datapath.sv @@
// Datapath: coefficient registers, history memories, shared multiply-
// accumulate unit, rounding and saturation, output register.
// Depends on btsbc_pkg and btsbc_ram.
`default_nettype none

module btsbc_datapath (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire btsbc_pkg::cmd_t                        cmd,
  output btsbc_pkg::status_t                          status,
  input  wire btsbc_pkg::in_payload_t                 in_data,
  input  wire logic                                   out_ready,
  output logic                                        out_valid,
  output btsbc_pkg::out_payload_t                     out_data,
  input  wire logic                                   cfg_write,
  input  wire logic [btsbc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [btsbc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  import btsbc_pkg::*;

  // Configuration registers.
  logic [FF_BITS-1:0] bass_feedforward, treble_feedforward;
  logic [FB_BITS-1:0] bass_feedback, treble_feedback;

  always_ff @(posedge clk) begin
    if (rst) begin
      bass_feedforward   <= FF_BITS'(1) << COEF_FRAC_BITS;
      bass_feedback      <= '0;
      treble_feedforward <= FF_BITS'(1) << COEF_FRAC_BITS;
      treble_feedback    <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_BASS_FF:   bass_feedforward   <= cfg_data[FF_BITS-1:0];
        REG_BASS_FB:   bass_feedback      <= cfg_data[FB_BITS-1:0];
        REG_TREBLE_FF: treble_feedforward <= cfg_data[FF_BITS-1:0];
        REG_TREBLE_FB: treble_feedback    <= cfg_data[FB_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Captured item.
  logic signed [SAMPLE_BITS-1:0]  x;
  logic        [CHANNEL_BITS-1:0] channel;
  logic        [ADDR_BITS-1:0]    addr;
  logic                           chan_ok;
  logic                           hist_ok;

  logic [ADDR_BITS+CHANNEL_BITS-1:0] in_addr_wide;
  logic [ADDR_BITS-1:0]              in_addr;
  logic [CHANNEL_BITS+6-1:0]         in_chan_wide;

  assign in_addr_wide = {ADDR_BITS'(0), in_data.channel_in};
  assign in_addr      = in_addr_wide[ADDR_BITS-1:0];
  assign in_chan_wide = (CHANNEL_BITS + 6)'(in_data.channel_in);

  // A row that has never been written reads as zero.
  logic [CH_SLOTS-1:0] row_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.commit && chan_ok) begin
      row_valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x       <= in_data.sample_in;
      channel <= in_data.channel_in;
      addr    <= in_addr;
      chan_ok <= in_chan_wide < (CHANNEL_BITS + 6)'(MAX_CHANNELS);
      hist_ok <= row_valid[in_addr];
    end
  end

  // History memories; row = {older sample, newer sample}.
  logic [ROW_BITS-1:0] bx_raw, by_raw, ty_raw;
  logic [ROW_BITS-1:0] bx_row, by_row, ty_row;
  logic [ROW_BITS-1:0] bx_new, by_new, ty_new;
  logic                hist_we;

  logic signed [SAMPLE_BITS-1:0] mid, y;

  assign hist_we = cmd.commit && chan_ok;
  assign bx_row  = hist_ok ? bx_raw : '0;
  assign by_row  = hist_ok ? by_raw : '0;
  assign ty_row  = hist_ok ? ty_raw : '0;
  assign bx_new  = {bx_row[SAMPLE_BITS-1:0], x};
  assign by_new  = {by_row[SAMPLE_BITS-1:0], mid};
  assign ty_new  = {ty_row[SAMPLE_BITS-1:0], y};

  btsbc_ram #(.WIDTH(ROW_BITS), .DEPTH(CH_SLOTS)) u_bass_in_hist (
    .clk(clk), .we(hist_we), .waddr(addr), .wdata(bx_new),
    .re(cmd.capture), .raddr(in_addr), .rdata(bx_raw)
  );

  btsbc_ram #(.WIDTH(ROW_BITS), .DEPTH(CH_SLOTS)) u_bass_out_hist (
    .clk(clk), .we(hist_we), .waddr(addr), .wdata(by_new),
    .re(cmd.capture), .raddr(in_addr), .rdata(by_raw)
  );

  btsbc_ram #(.WIDTH(ROW_BITS), .DEPTH(CH_SLOTS)) u_treble_out_hist (
    .clk(clk), .we(hist_we), .waddr(addr), .wdata(ty_new),
    .re(cmd.capture), .raddr(in_addr), .rdata(ty_raw)
  );

  // Operand and coefficient selection for the shared multiplier.
  logic [FF_BITS-1:0]            ff_sel;
  logic [FB_BITS-1:0]            fb_sel;
  logic signed [SAMPLE_BITS-1:0] stage_x;
  logic [ROW_BITS-1:0]           xh_row, yh_row;
  logic signed [COEF_BITS-1:0]   coef_op;
  logic signed [SAMPLE_BITS-1:0] data_op;

  always_comb begin
    if (cmd.stage == STAGE_TREBLE) begin
      ff_sel  = treble_feedforward;
      fb_sel  = treble_feedback;
      stage_x = mid;
      xh_row  = by_row;
      yh_row  = ty_row;
    end else begin
      ff_sel  = bass_feedforward;
      fb_sel  = bass_feedback;
      stage_x = x;
      xh_row  = bx_row;
      yh_row  = by_row;
    end
    case (cmd.step)
      3'd0: begin
        coef_op = ff_sel[COEF_BITS-1:0];
        data_op = stage_x;
      end
      3'd1: begin
        coef_op = ff_sel[2*COEF_BITS-1:COEF_BITS];
        data_op = xh_row[SAMPLE_BITS-1:0];
      end
      3'd2: begin
        coef_op = ff_sel[3*COEF_BITS-1:2*COEF_BITS];
        data_op = xh_row[ROW_BITS-1:SAMPLE_BITS];
      end
      3'd3: begin
        coef_op = fb_sel[COEF_BITS-1:0];
        data_op = yh_row[SAMPLE_BITS-1:0];
      end
      3'd4: begin
        coef_op = fb_sel[2*COEF_BITS-1:COEF_BITS];
        data_op = yh_row[ROW_BITS-1:SAMPLE_BITS];
      end
      default: begin
        coef_op = '0;
        data_op = '0;
      end
    endcase
  end

  // Product is registered; the accumulator folds it in on the next step.
  // Feedback terms (steps three and four) are subtracted.
  logic signed [PROD_BITS-1:0] product;
  logic signed [ACC_BITS-1:0]  acc;
  logic signed [ACC_BITS-1:0]  prod_ext;
  logic                        prod_sub;

  assign prod_ext = ACC_BITS'(product);
  assign prod_sub = (cmd.step == 3'd4) || (cmd.step == 3'd5);

  always_ff @(posedge clk) begin
    if (cmd.mac_run) begin
      product <= coef_op * data_op;
      if (cmd.step == '0) begin
        acc <= '0;
      end else if (prod_sub) begin
        acc <= acc - prod_ext;
      end else begin
        acc <= acc + prod_ext;
      end
    end
  end

  // Round to nearest, ties upward, then saturate to the sample range.
  logic signed [ACC_BITS-1:0]    rnd_sum;
  logic signed [Q_BITS-1:0]      q;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic                          q_fits;

  assign rnd_sum = acc + ACC_BITS'(1 << (COEF_FRAC_BITS - 1));
  assign q       = rnd_sum[ACC_BITS-1:COEF_FRAC_BITS];
  assign q_fits  = (&q[Q_BITS-1:SAMPLE_BITS-1]) || !(|q[Q_BITS-1:SAMPLE_BITS-1]);

  always_comb begin
    if (q_fits) begin
      sat = q[SAMPLE_BITS-1:0];
    end else if (q[Q_BITS-1]) begin
      sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round_bass) begin
      mid <= sat;
    end
    if (cmd.round_treble) begin
      y <= sat;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.sample_out  <= chan_ok ? y : x;
      out_data.channel_out <= channel;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

@@ design/bass_treble_shelf_biquad_cascade_core.sv @@
// Bass low-shelf then treble high-shelf biquad cascade, per-channel state.
// A result becomes valid once its sample has passed both stages and the
// commit, when the output register is free. A new sample is taken only
// after the previous one commits; a single shared MAC does all ten products.
// Reset (synchronous, active high) restores the unity-gain coefficients and
// clears every channel's histories at once through per-channel valid bits.
`default_nettype none

module bass_treble_shelf_biquad_cascade_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire btsbc_pkg::in_payload_t                 in_data,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output btsbc_pkg::out_payload_t                     out_data,
  input  wire logic                                   cfg_write,
  input  wire logic [btsbc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [btsbc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  import btsbc_pkg::*;

  // The controller walks each sample through the bass stage (five products
  // and a final accumulate), a rounding step, the same for the treble
  // stage, and then a commit step. The commit writes all three history
  // rows for the channel and loads the output register in the same cycle,
  // so the next sample always sees fully updated state.
  //
  // The output register decouples the two sides: a new input transfer is
  // taken while a previous result still waits for its consumer. Only a
  // finished result that finds the output register occupied holds the
  // controller in its commit state.
  //
  // Channels at or above the configured channel count pass their sample
  // straight through and leave every history untouched.

  cmd_t    cmd;
  status_t status;

  btsbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  btsbc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

@@ design/btsbc_checker.sv @@
// Port-level checks for the biquad cascade top level, with its bind.
// Depends on bass_treble_shelf_biquad_cascade_core.
`default_nettype none

module btsbc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);

  // A held result stays offered until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // One sample in flight: an input transfer closes the input side.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a sample is in progress");

  // A result appears only as the controller returns to accepting input.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared while a sample is still in progress");

  // Reset empties the output register.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bass_treble_shelf_biquad_cascade_core btsbc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready)
);

`default_nettype wire

@@ sim/btsbc_scoreboard_pkg.sv @@
// Scoreboard for the bass and treble shelf cascade: a bit-exact predictor of
// both biquad stages with per-channel histories, and the queue of expected
// output samples. Depends on btsbc_pkg for payload types and sizes.
package btsbc_scoreboard_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import btsbc_pkg::*;

  typedef logic [CFG_DATA_BITS-1:0] cfg_word_t;

  localparam int PRINT_CAP = 100;

  class tone_scoreboard;
    cfg_word_t bass_ff;
    cfg_word_t bass_fb;
    cfg_word_t treble_ff;
    cfg_word_t treble_fb;
    longint bass_x [MAX_CHANNELS][2];
    longint bass_y [MAX_CHANNELS][2];
    longint treble_y [MAX_CHANNELS][2];
    out_payload_t pending_samples [$];
    int errors;

    function new();
      bass_ff   = cfg_word_t'(1) << COEF_FRAC_BITS;
      bass_fb   = '0;
      treble_ff = cfg_word_t'(1) << COEF_FRAC_BITS;
      treble_fb = '0;
      foreach (bass_x[c, k]) begin
        bass_x[c][k]   = 0;
        bass_y[c][k]   = 0;
        treble_y[c][k] = 0;
      end
      errors = 0;
    endfunction

    // Feedback registers keep only their low two coefficient fields.
    function void apply_config(cfg_reg_t index, cfg_word_t value);
      case (index)
        REG_BASS_FF:   bass_ff = value;
        REG_BASS_FB:   bass_fb = value & ((cfg_word_t'(1) << FB_BITS) - 1);
        REG_TREBLE_FF: treble_ff = value;
        REG_TREBLE_FB: treble_fb = value & ((cfg_word_t'(1) << FB_BITS) - 1);
        default: ;
      endcase
    endfunction

    static function longint coef(cfg_word_t word, int slot);
      logic signed [COEF_BITS-1:0] field;
      field = word[slot*COEF_BITS +: COEF_BITS];
      return longint'(field);
    endfunction

    // One direct-form-I section: exact sum, round half up, saturate.
    static function longint shelf_stage(cfg_word_t ff, cfg_word_t fb, longint x,
                                        longint x1, longint x2, longint y1, longint y2);
      longint acc;
      longint q;
      longint top;
      longint bottom;
      acc = coef(ff, 0) * x + coef(ff, 1) * x1 + coef(ff, 2) * x2
          - coef(fb, 0) * y1 - coef(fb, 1) * y2;
      q = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      top    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
      bottom = -(longint'(1) <<< (SAMPLE_BITS - 1));
      if (q > top) q = top;
      if (q < bottom) q = bottom;
      return q;
    endfunction

    function void note_sample(in_payload_t item);
      out_payload_t want;
      longint x;
      longint mid;
      longint y;
      int ch;
      x  = longint'($signed(item.sample_in));
      ch = int'(item.channel_in);
      y  = x;
      if (ch < MAX_CHANNELS) begin
        mid = shelf_stage(bass_ff, bass_fb, x, bass_x[ch][0], bass_x[ch][1],
                          bass_y[ch][0], bass_y[ch][1]);
        y = shelf_stage(treble_ff, treble_fb, mid, bass_y[ch][0], bass_y[ch][1],
                        treble_y[ch][0], treble_y[ch][1]);
        bass_x[ch][1]   = bass_x[ch][0];
        bass_x[ch][0]   = x;
        bass_y[ch][1]   = bass_y[ch][0];
        bass_y[ch][0]   = mid;
        treble_y[ch][1] = treble_y[ch][0];
        treble_y[ch][0] = y;
      end
      want.sample_out  = y[SAMPLE_BITS-1:0];
      want.channel_out = item.channel_in;
      pending_samples.push_back(want);
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_sample(out_payload_t got);
      out_payload_t want;
      if (pending_samples.size() == 0) begin
        report($sformatf("unexpected sample %0d on channel %0d",
                         $signed(got.sample_out), got.channel_out));
        return;
      end
      want = pending_samples.pop_front();
      if (got.sample_out !== want.sample_out)
        report($sformatf("sample %0d, expected %0d (channel %0d)",
                         $signed(got.sample_out), $signed(want.sample_out),
                         want.channel_out));
      if (got.channel_out !== want.channel_out)
        report($sformatf("channel %0d, expected %0d", got.channel_out, want.channel_out));
    endtask

    task final_check();
      if (pending_samples.size() != 0)
        report($sformatf("%0d expected samples never came out", pending_samples.size()));
    endtask
  endclass

endpackage

@@ sim/bass_treble_shelf_biquad_cascade_core_test.sv @@
// Self-checking test of bass_treble_shelf_biquad_cascade_core: drives samples
// and coefficient writes, and checks every output transfer against the
// scoreboard. Depends on btsbc_pkg and btsbc_scoreboard_pkg.
module bass_treble_shelf_biquad_cascade_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import btsbc_pkg::*;
  import btsbc_scoreboard_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [COEF_BITS-1:0] COEF_MAX  = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic [COEF_BITS-1:0] COEF_MIN  = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam logic [COEF_BITS-1:0] COEF_ONE  = COEF_BITS'(1 << COEF_FRAC_BITS);
  localparam logic [COEF_BITS-1:0] COEF_ZERO = '0;
  localparam int RANDOM_PHASES  = 7;
  localparam int PHASE_SAMPLES  = 150;
  localparam int SETTLE_CYCLES  = 32;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_payload_t in_data;
  logic out_valid;
  logic out_ready;
  out_payload_t out_data;
  logic cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  cfg_word_t cfg_data;

  // Cleared for the final phase so that the block also runs flat out.
  logic idle_on;

  tone_scoreboard sb = new();

  bass_treble_shelf_biquad_cascade_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Both channels are observed at the rising edge, where the values that
  // decide a transfer are settled since the stimulus moves on falling edges.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_sample(in_data);
      if (out_valid && out_ready) sb.check_sample(out_data);
    end
  end

  // The output side stalls in random bursts while idling is enabled, and
  // otherwise accepts every cycle.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // A generous ceiling: a correct run needs well under a fifth of this.
  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

  function automatic cfg_word_t pack_coefs(logic [COEF_BITS-1:0] c0, logic [COEF_BITS-1:0] c1,
                                           logic [COEF_BITS-1:0] c2);
    return {c2, c1, c0};
  endfunction

  function automatic logic [COEF_BITS-1:0] rand_coef(int lo, int hi);
    return COEF_BITS'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  // Presents one sample, possibly after a short idle burst, waits for the
  // rising edge where its transfer completes, and drops the valid line at
  // the following falling edge, where the call returns.
  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] sample,
                             logic [CHANNEL_BITS-1:0] channel);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.sample_in = sample;
    in_data.channel_in = channel;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Stops the input stream and waits until every expected sample has been
  // seen, so that the block is idle afterwards.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_samples.size() != 0) @(negedge clk);
  endtask

  // Writes all four coefficient registers back to back; the scoreboard takes
  // the same values, which is safe because the block is idle.
  task automatic load_coefficients(cfg_word_t bass_ff, cfg_word_t bass_fb,
                                   cfg_word_t treble_ff, cfg_word_t treble_fb);
    cfg_reg_t regs [4] = '{REG_BASS_FF, REG_BASS_FB, REG_TREBLE_FF, REG_TREBLE_FB};
    cfg_word_t words [4];
    words = '{bass_ff, bass_fb, treble_ff, treble_fb};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_write = 1'b1;
      cfg_index = regs[i];
      cfg_data = words[i];
      sb.apply_config(regs[i], words[i]);
    end
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  initial begin
    cfg_word_t ff_b;
    cfg_word_t fb_b;
    cfg_word_t ff_t;
    cfg_word_t fb_t;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [CHANNEL_BITS-1:0] channel;
    logic [CHANNEL_BITS-1:0] focus_channel;

    rst = 1'b1;
    idle_on = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = REG_BASS_FF;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset coefficients give unity gain, so full-scale values on the outer
    // channels must come back untouched.
    send_sample(SAMPLE_MAX, 3'd0);
    send_sample(SAMPLE_MIN, 3'd7);
    send_sample(24'sd0, 3'd3);
    send_sample(-24'sd1, 3'd5);
    send_sample(24'sd1, 3'd1);

    // Largest positive feedforward and most negative feedback gains: both
    // stages are driven hard into saturation and the histories hold the
    // clipped values.
    drain();
    load_coefficients(pack_coefs(COEF_MAX, COEF_MAX, COEF_MAX),
                      pack_coefs(COEF_MIN, COEF_MIN, COEF_ZERO),
                      pack_coefs(COEF_MAX, COEF_MAX, COEF_MAX),
                      pack_coefs(COEF_MIN, COEF_MIN, COEF_ZERO));
    send_sample(SAMPLE_MAX, 3'd2);
    send_sample(SAMPLE_MAX, 3'd2);
    send_sample(SAMPLE_MIN, 3'd2);
    send_sample(SAMPLE_MIN, 3'd4);
    send_sample(24'sd12345, 3'd6);
    send_sample(24'sd0, 3'd2);

    // The opposite corner; the feedback words also carry ones above their
    // width, which the block has to discard.
    drain();
    load_coefficients(pack_coefs(COEF_MIN, COEF_MIN, COEF_MIN),
                      pack_coefs(COEF_MAX, COEF_MAX, COEF_MAX),
                      pack_coefs(COEF_MIN, COEF_MIN, COEF_MIN),
                      pack_coefs(COEF_MAX, COEF_MAX, COEF_MAX));
    send_sample(SAMPLE_MAX, 3'd3);
    send_sample(SAMPLE_MIN, 3'd3);
    send_sample(24'sd1, 3'd3);
    send_sample(-24'sd1, 3'd0);

    // A bass gain of one least significant bit puts the sum exactly on a
    // half step, so ties must round towards positive infinity.
    drain();
    load_coefficients(pack_coefs(COEF_BITS'(1), COEF_ZERO, COEF_ZERO), '0,
                      pack_coefs(COEF_ONE, COEF_ZERO, COEF_ZERO), '0);
    send_sample(24'sd8192, 3'd1);
    send_sample(-24'sd8192, 3'd1);
    send_sample(24'sd24576, 3'd0);
    send_sample(-24'sd24576, 3'd0);
    send_sample(24'sd8191, 3'd4);
    send_sample(-24'sd8193, 3'd4);

    // Random phases. Most use stable, moderate filters so that the histories
    // carry real signal; some use raw register contents, one goes back to
    // the reset gains, and the last one runs without any idling.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case (p % 4)
        1: begin
          ff_b = cfg_word_t'({$urandom, $urandom});
          fb_b = cfg_word_t'({$urandom, $urandom});
          ff_t = cfg_word_t'({$urandom, $urandom});
          fb_t = cfg_word_t'({$urandom, $urandom});
        end
        3: begin
          ff_b = pack_coefs(COEF_ONE, COEF_ZERO, COEF_ZERO);
          fb_b = '0;
          ff_t = pack_coefs(COEF_ONE, COEF_ZERO, COEF_ZERO);
          fb_t = '0;
        end
        default: begin
          ff_b = pack_coefs(rand_coef(4096, 32767), rand_coef(-16384, 16384),
                            rand_coef(-8192, 8192));
          fb_b = pack_coefs(rand_coef(-8192, 8192), rand_coef(-8192, 8192), COEF_ZERO);
          ff_t = pack_coefs(rand_coef(4096, 32767), rand_coef(-16384, 16384),
                            rand_coef(-8192, 8192));
          fb_t = pack_coefs(rand_coef(-8192, 8192), rand_coef(-8192, 8192), COEF_ZERO);
        end
      endcase
      load_coefficients(ff_b, fb_b, ff_t, fb_t);
      idle_on = (p != RANDOM_PHASES - 1);
      focus_channel = CHANNEL_BITS'($urandom_range(0, MAX_CHANNELS - 1));
      repeat (PHASE_SAMPLES) begin
        // A third of the samples stay on one channel so that its histories
        // see long runs; the rest spread over all channels.
        if ($urandom_range(0, 2) == 0) channel = focus_channel;
        else channel = CHANNEL_BITS'($urandom_range(0, MAX_CHANNELS - 1));
        case ($urandom_range(0, 9))
          0: sample = SAMPLE_MAX;
          1: sample = SAMPLE_MIN;
          2, 3, 4: sample = SAMPLE_BITS'(int'($urandom_range(0, 131072)) - 65536);
          default: sample = SAMPLE_BITS'($urandom);
        endcase
        send_sample(sample, channel);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    sb.final_check();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
